[hdl/gcg_pkg.sv]
// ----------------------------------------------------------------------------
// gcg_pkg
// Shared types, constants and helpers for the gilbert curve coordinate
// generator: frame layout, controller states, command and status groups.
// ----------------------------------------------------------------------------
package gcg_pkg;

    localparam int CW              = 12;   // signed width of positions and vectors
    localparam int DIM_W           = 11;   // width of a rectangle side
    localparam int IDX_W           = 20;   // point index width
    localparam int TOT_W           = 21;   // total point count width
    localparam int DEF_MAX_DIM     = 1024;
    localparam int DEF_STACK_DEPTH = 32;

    localparam logic REG_AREA_WIDTH  = 1'b0;
    localparam logic REG_AREA_HEIGHT = 1'b1;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [1:0]    step_t;

    typedef struct packed {
        coord_t     x;
        coord_t     y;
        coord_t     ax;
        coord_t     ay;
        coord_t     bx;
        coord_t     by;
        logic [1:0] phase;
    } frame_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_EXAM,
        ST_PUSH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;    // request accepted
        logic finish;   // stack empty, walk over
        logic read;     // read top frame
        logic exam;     // act on top frame
        logic push;     // push pending child
        logic emit;     // load result register
    } cmd_t;

    typedef struct packed {
        logic need_frame;
        logic stack_empty;
        logic leaf;
        logic has_child;
        logic out_free;
    } stat_t;

    function automatic step_t sign_of(input coord_t v);
        return {v[CW-1], |v};
    endfunction

    function automatic coord_t sx(input step_t d);
        return {{(CW-2){d[1]}}, d};
    endfunction

    function automatic coord_t mag(input coord_t v);
        return v[CW-1] ? -v : v;
    endfunction

    // halve, truncating toward zero
    function automatic coord_t halve(input coord_t v);
        coord_t t;
        t = v + {{(CW-1){1'b0}}, v[CW-1]};
        return t >>> 1;
    endfunction

endpackage

[hdl/gcg_ctrl.sv]
// ----------------------------------------------------------------------------
// gcg_ctrl
// Sequencer for the frame walk: takes a request, walks the stack until a
// fill holds a cell or the walk ends, then loads the result register.
// ----------------------------------------------------------------------------
module gcg_ctrl
    import gcg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (!stat.need_frame || stat.stack_empty)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_EXAM;
                end
            end
            ST_EXAM:
            begin
                if (!stat.leaf && stat.has_child)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    state_next = ST_ADV;
                end
            end
            ST_PUSH:
            begin
                state_next = ST_ADV;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            ST_ADV:
            begin
                if (stat.need_frame)
                begin
                    cmd.finish = stat.stack_empty;
                    cmd.read   = !stat.stack_empty;
                end
            end
            ST_EXAM:
            begin
                cmd.exam = 1'b1;
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hdl/gcg_datapath.sv]
// ----------------------------------------------------------------------------
// gcg_datapath
// Frame stack, fill walker, child frame arithmetic and result register.
// ----------------------------------------------------------------------------
module gcg_datapath
    import gcg_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output stat_t            stat,
    input  logic             restart,
    input  logic [DIM_W-1:0] cfg_width,
    input  logic [DIM_W-1:0] cfg_height,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [9:0]       coord_x,
    output logic [9:0]       coord_y,
    output logic [IDX_W-1:0] point_index,
    output logic             is_last,
    output logic             finished
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int PW  = $clog2(STACK_DEPTH + 1);
    localparam int LIM = (MAX_DIM < 1024) ? MAX_DIM : 1024;
    localparam logic [DIM_W-1:0] LIM_V = DIM_W'(LIM);

    frame_t stack_mem [STACK_DEPTH];
    frame_t rd_frame_reg;
    frame_t child_reg, child_next;

    logic [PW-1:0]    top_reg, top_next, top_m1;
    logic [DIM_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic             done_reg, done_next;
    coord_t           fx_reg, fx_next, fy_reg, fy_next;
    step_t            fdx_reg, fdx_next, fdy_reg, fdy_next;

    logic             ov_reg, ov_next;
    logic [9:0]       ox_reg, ox_next, oy_reg, oy_next;
    logic [IDX_W-1:0] oi_reg, oi_next;
    logic             ol_reg, ol_next, of_reg, of_next;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    frame_t           mem_wdata;

    logic [DIM_W-1:0] cw, ch;
    coord_t           w, h, ax2, ay2, bx2, by2, bx2a, by2a, w2, h2, ax2a, ay2a;
    step_t            dax, day, dbx, dby;
    logic [13:0]      two_w, three_h;
    logic             wide, leaf, has_child, last;
    frame_t           f, root;

    assign f      = rd_frame_reg;
    assign top_m1 = top_reg - PW'(1);

    // clamp of the configured size
    assign cw = (cfg_width == '0) ? DIM_W'(1) : ((cfg_width > LIM_V) ? LIM_V : cfg_width);
    assign ch = (cfg_height == '0) ? DIM_W'(1) : ((cfg_height > LIM_V) ? LIM_V : cfg_height);

    always_comb
    begin
        root       = '0;
        if (cw >= ch)
        begin
            root.ax = coord_t'(cw);
            root.by = coord_t'(ch);
        end
        else
        begin
            root.ay = coord_t'(ch);
            root.bx = coord_t'(cw);
        end
    end

    // child frame of the top frame
    always_comb
    begin
        w       = mag(f.ax + f.ay);
        h       = mag(f.bx + f.by);
        dax     = sign_of(f.ax);
        day     = sign_of(f.ay);
        dbx     = sign_of(f.bx);
        dby     = sign_of(f.by);
        ax2     = halve(f.ax);
        ay2     = halve(f.ay);
        bx2     = halve(f.bx);
        by2     = halve(f.by);
        w2      = mag(ax2 + ay2);
        h2      = mag(bx2 + by2);
        two_w   = {1'b0, w[CW-1:0], 1'b0};
        three_h = {1'b0, h[CW-1:0], 1'b0} + 14'(h);
        wide    = two_w > three_h;
        ax2a    = ax2;
        ay2a    = ay2;
        bx2a    = bx2;
        by2a    = by2;
        if (w2[0] && (w > coord_t'(2)))
        begin
            ax2a = ax2 + sx(dax);
            ay2a = ay2 + sx(day);
        end
        if (h2[0] && (h > coord_t'(2)))
        begin
            bx2a = bx2 + sx(dbx);
            by2a = by2 + sx(dby);
        end
        leaf       = (f.phase == 2'd0) && ((h == coord_t'(1)) || (w == coord_t'(1)));
        has_child  = wide ? (f.phase < 2'd2) : (f.phase < 2'd3);
        child_next = child_reg;
        if (cmd.exam)
        begin
            child_next.phase = 2'd0;
            if (wide)
            begin
                if (f.phase == 2'd0)
                begin
                    child_next.x  = f.x;
                    child_next.y  = f.y;
                    child_next.ax = ax2a;
                    child_next.ay = ay2a;
                end
                else
                begin
                    child_next.x  = f.x + ax2a;
                    child_next.y  = f.y + ay2a;
                    child_next.ax = f.ax - ax2a;
                    child_next.ay = f.ay - ay2a;
                end
                child_next.bx = f.bx;
                child_next.by = f.by;
            end
            else
            begin
                case (f.phase)
                    2'd0:
                    begin
                        child_next.x  = f.x;
                        child_next.y  = f.y;
                        child_next.ax = bx2a;
                        child_next.ay = by2a;
                        child_next.bx = ax2;
                        child_next.by = ay2;
                    end
                    2'd1:
                    begin
                        child_next.x  = f.x + bx2a;
                        child_next.y  = f.y + by2a;
                        child_next.ax = f.ax;
                        child_next.ay = f.ay;
                        child_next.bx = f.bx - bx2a;
                        child_next.by = f.by - by2a;
                    end
                    default:
                    begin
                        child_next.x  = f.x + (f.ax - sx(dax)) + (bx2a - sx(dbx));
                        child_next.y  = f.y + (f.ay - sx(day)) + (by2a - sx(dby));
                        child_next.ax = -bx2a;
                        child_next.ay = -by2a;
                        child_next.bx = -(f.ax - ax2);
                        child_next.by = -(f.ay - ay2);
                    end
                endcase
            end
        end
    end

    assign last = ({1'b0, count_reg} + TOT_W'(1)) == total_reg;

    always_comb
    begin
        top_next   = top_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        total_next = total_reg;
        done_next  = done_reg;
        fx_next    = fx_reg;
        fy_next    = fy_reg;
        fdx_next   = fdx_reg;
        fdy_next   = fdy_reg;
        ov_next    = ov_reg && !out_ready;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oi_next    = oi_reg;
        ol_next    = ol_reg;
        of_next    = of_reg;
        mem_we     = 1'b0;
        mem_addr   = top_m1[AW-1:0];
        mem_wdata  = f;
        mem_wdata.phase = f.phase + 2'd1;

        if (cmd.start && restart)
        begin
            mem_we     = 1'b1;
            mem_addr   = '0;
            mem_wdata  = root;
            top_next   = PW'(1);
            fill_next  = '0;
            count_next = '0;
            done_next  = 1'b0;
            total_next = TOT_W'(cw) * TOT_W'(ch);
        end
        if (cmd.finish)
        begin
            done_next = 1'b1;
        end
        if (cmd.exam)
        begin
            if (leaf)
            begin
                fx_next  = f.x;
                fy_next  = f.y;
                top_next = top_m1;
                if (h == coord_t'(1))
                begin
                    fdx_next  = dax;
                    fdy_next  = day;
                    fill_next = w[DIM_W-1:0];
                end
                else
                begin
                    fdx_next  = dbx;
                    fdy_next  = dby;
                    fill_next = h[DIM_W-1:0];
                end
            end
            else
            begin
                mem_we = 1'b1;
                if (!has_child)
                begin
                    top_next = top_m1;
                end
            end
        end
        if (cmd.push && (top_reg < PW'(STACK_DEPTH)))
        begin
            mem_we    = 1'b1;
            mem_addr  = top_reg[AW-1:0];
            mem_wdata = child_reg;
            top_next  = top_reg + PW'(1);
        end
        if (cmd.emit)
        begin
            ov_next = 1'b1;
            if (done_reg)
            begin
                ox_next = '0;
                oy_next = '0;
                oi_next = '0;
                ol_next = 1'b0;
                of_next = 1'b1;
            end
            else
            begin
                ox_next    = fx_reg[9:0];
                oy_next    = fy_reg[9:0];
                oi_next    = count_reg;
                ol_next    = last;
                of_next    = 1'b0;
                fx_next    = fx_reg + sx(fdx_reg);
                fy_next    = fy_reg + sx(fdy_reg);
                fill_next  = fill_reg - DIM_W'(1);
                count_next = count_reg + IDX_W'(1);
                if (last)
                begin
                    done_next = 1'b1;
                    top_next  = '0;
                    fill_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.read)
        begin
            rd_frame_reg <= stack_mem[top_m1[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            top_reg   <= top_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        child_reg <= child_next;
        total_reg <= total_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        fdx_reg   <= fdx_next;
        fdy_reg   <= fdy_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oi_reg    <= oi_next;
        ol_reg    <= ol_next;
        of_reg    <= of_next;
    end

    assign stat.need_frame  = !done_reg && (fill_reg == '0);
    assign stat.stack_empty = (top_reg == '0);
    assign stat.leaf        = leaf;
    assign stat.has_child   = has_child;
    assign stat.out_free    = !ov_reg || out_ready;

    assign out_valid   = ov_reg;
    assign coord_x     = ox_reg;
    assign coord_y     = oy_reg;
    assign point_index = oi_reg;
    assign is_last     = ol_reg;
    assign finished    = of_reg;

endmodule

[hdl/gilbert_curve_coordinate_generator_core.sv]
// ----------------------------------------------------------------------------
// gilbert_curve_coordinate_generator_core
// Generalised hilbert (gilbert2d) curve walker over a configured rectangle.
// ----------------------------------------------------------------------------
// a request goes through ADV, then EMIT when the current fill holds a cell
// each stack frame visited takes a read (ADV) and an act (EXAM), plus a PUSH per child
// one request at a time; the result load in EMIT waits until the result register is free
// reset: walk marked finished, stack empty, size registers 1 by 1
// frame stack contents are not cleared by reset
module gilbert_curve_coordinate_generator_core
    import gcg_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    // request channel
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             restart,
    // result channel
    output logic             out_valid,
    input  logic             out_ready,
    output logic [9:0]       coord_x,
    output logic [9:0]       coord_y,
    output logic [IDX_W-1:0] point_index,
    output logic             is_last,
    output logic             finished,
    // configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             wr_en;
    cmd_t             cmd;
    stat_t            stat;

    // register write at the access phase, word index from paddr[2]
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_AREA_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_AREA_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default:         width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // read back of the raw register values
    assign prdata = (paddr[2] == REG_AREA_HEIGHT) ? {21'd0, height_reg} : {21'd0, width_reg};

    // sequencer: request, stack walk, result load
    gcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // frame stack, fill walker and result register
    gcg_datapath #(
        .MAX_DIM     (MAX_DIM),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .restart     (restart),
        .cfg_width   (width_reg),
        .cfg_height  (height_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .point_index (point_index),
        .is_last     (is_last),
        .finished    (finished)
    );

endmodule

[hdl/gcg_checker.sv]
// ----------------------------------------------------------------------------
// gcg_checker
// Port level checks on the result channel of the curve generator.
// ----------------------------------------------------------------------------
module gcg_checker
    import gcg_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [9:0]       coord_x,
    input logic [9:0]       coord_y,
    input logic [IDX_W-1:0] point_index,
    input logic             is_last,
    input logic             finished
);

    // finished result carries no coordinate
    a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> (coord_x == '0 && coord_y == '0 && point_index == '0))
        else $error("finished result with coordinate");

    a_last_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_last && finished))
        else $error("last and finished together");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(point_index) && $stable(finished)))
        else $error("stalled result changed");

endmodule

bind gilbert_curve_coordinate_generator_core gcg_checker u_gcg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .point_index (point_index),
    .is_last     (is_last),
    .finished    (finished)
);
